FILE: design/pbu_pkg.sv
// Shared types and constants for the pixel blend unit.
package pbu_pkg;

	// Number of colour channels in one pixel
	localparam int unsigned CH_COUNT = 3;
	// Width of one colour channel
	localparam int unsigned CH_W     = 8;
	// Width of a doubled 8x8 product
	localparam int unsigned PROD_W   = 2 * CH_W + 1;
	// Width of the divide-by-255 estimate
	localparam int unsigned QE_W     = PROD_W - CH_W + 1;
	// Width of the remainder after the estimate
	localparam int unsigned REM_W    = PROD_W + 1;
	// Full-scale channel value
	localparam logic [CH_W-1:0] MAXV = 8'd255;

	// Blend selection codes
	typedef enum logic [1:0] {
		MODE_MULTIPLY = 2'd0,
		MODE_SUBTRACT = 2'd1,
		MODE_SCREEN   = 2'd2,
		MODE_OVERLAY  = 2'd3
	} blend_mode_t;

	// Per-channel control that travels down the pipeline
	typedef struct packed {
		logic            inv;   // result is 255 minus the quotient
		logic            sub;   // result is the clamped difference
		logic [CH_W-1:0] diff;  // clamped difference for subtract
	} ch_ctrl_t;

endpackage

FILE: design/pixel_blend_unit.sv
// Throughput: one pixel per cycle while out_stall is low; each stage holds only while the stage after it
// is full and blocked, so bubbles are squeezed out during an output stall.
// Stages: operand select, 8x8 multiply, divide-by-255 estimate, correction and output.
// Reset clears all stage valid bits and sets blend_mode to multiply.
module pixel_blend_unit
	import pbu_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic [1:0]      cfg_data,
	input  logic            in_valid,
	output logic            in_stall,
	input  logic [CH_W-1:0] top_red,
	input  logic [CH_W-1:0] top_green,
	input  logic [CH_W-1:0] top_blue,
	input  logic [CH_W-1:0] bottom_red,
	input  logic [CH_W-1:0] bottom_green,
	input  logic [CH_W-1:0] bottom_blue,
	output logic            out_valid,
	input  logic            out_stall,
	output logic [CH_W-1:0] out_red,
	output logic [CH_W-1:0] out_green,
	output logic [CH_W-1:0] out_blue
);

	blend_mode_t blend_mode_q;

	logic [CH_COUNT-1:0][CH_W-1:0] a_in, b_in;
	logic [CH_COUNT-1:0][CH_W-1:0] x_nx, y_nx;
	logic [CH_COUNT-1:0]           dbl_nx;
	ch_ctrl_t [CH_COUNT-1:0]       ctrl_nx;

	logic                          valid_s1, valid_s2, valid_s3, valid_s4;
	logic                          rdy1, rdy2, rdy3, rdy4;

	logic [CH_COUNT-1:0][CH_W-1:0]   x_s1, y_s1;
	logic [CH_COUNT-1:0]             dbl_s1;
	ch_ctrl_t [CH_COUNT-1:0]         ctrl_s1;
	logic [CH_COUNT-1:0][PROD_W-1:0] p_s2;
	ch_ctrl_t [CH_COUNT-1:0]         ctrl_s2;
	logic [CH_COUNT-1:0][PROD_W-1:0] p_s3;
	logic [CH_COUNT-1:0][QE_W-1:0]   qe_s3;
	ch_ctrl_t [CH_COUNT-1:0]         ctrl_s3;
	logic [CH_COUNT-1:0][CH_W-1:0]   res_s4;

	logic [CH_COUNT-1:0][2*CH_W-1:0] prod_nx;
	logic [CH_COUNT-1:0][REM_W-1:0]  qe_sum;
	logic [CH_COUNT-1:0][REM_W-1:0]  rem_nx;
	logic [CH_COUNT-1:0][QE_W-1:0]   q_nx;
	logic [CH_COUNT-1:0][CH_W-1:0]   res_nx;

	// Hold the blend mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blend_mode_q <= MODE_MULTIPLY;
		end else if (cfg_we) begin
			blend_mode_q <= blend_mode_t'(cfg_data);
		end
	end

	// Stage ready chain: a stage advances when empty or when the next one takes its word
	assign rdy4     = !valid_s4 || !out_stall;
	assign rdy3     = !valid_s3 || rdy4;
	assign rdy2     = !valid_s2 || rdy3;
	assign rdy1     = !valid_s1 || rdy2;
	assign in_stall = !rdy1;

	assign a_in = {top_blue, top_green, top_red};
	assign b_in = {bottom_blue, bottom_green, bottom_red};

	// Select operands and flags per channel
	always_comb begin
		for (int c = 0; c < CH_COUNT; c++) begin
			x_nx[c]         = a_in[c];
			y_nx[c]         = b_in[c];
			dbl_nx[c]       = 1'b0;
			ctrl_nx[c].inv  = 1'b0;
			ctrl_nx[c].sub  = 1'b0;
			ctrl_nx[c].diff = (a_in[c] > b_in[c]) ? (a_in[c] - b_in[c]) : '0;
			unique case (blend_mode_q)
				MODE_MULTIPLY: begin
					dbl_nx[c] = 1'b0;
				end
				MODE_SUBTRACT: begin
					ctrl_nx[c].sub = 1'b1;
				end
				MODE_SCREEN: begin
					x_nx[c]        = ~a_in[c];
					y_nx[c]        = ~b_in[c];
					ctrl_nx[c].inv = 1'b1;
				end
				MODE_OVERLAY: begin
					dbl_nx[c] = 1'b1;
					if (a_in[c][CH_W-1]) begin
						x_nx[c]        = ~a_in[c];
						y_nx[c]        = ~b_in[c];
						ctrl_nx[c].inv = 1'b1;
					end
				end
				default: begin
					dbl_nx[c] = 1'b0;
				end
			endcase
		end
	end

	// Multiply, estimate the quotient, then correct it and apply the final flip or select the clamped difference
	always_comb begin
		for (int c = 0; c < CH_COUNT; c++) begin
			prod_nx[c] = x_s1[c] * y_s1[c];
			qe_sum[c]  = {1'b0, p_s2[c]}
				+ {{(REM_W-PROD_W+CH_W){1'b0}}, p_s2[c][PROD_W-1:CH_W]};
			rem_nx[c]  = {1'b0, p_s3[c]}
				- (({{(REM_W-QE_W){1'b0}}, qe_s3[c]} << CH_W)
				- {{(REM_W-QE_W){1'b0}}, qe_s3[c]});
			q_nx[c]    = qe_s3[c] + {{(QE_W-1){1'b0}},
				(rem_nx[c] >= {{(REM_W-CH_W){1'b0}}, MAXV})};
			if (ctrl_s3[c].sub) begin
				res_nx[c] = ctrl_s3[c].diff;
			end else if (ctrl_s3[c].inv) begin
				res_nx[c] = MAXV - q_nx[c][CH_W-1:0];
			end else begin
				res_nx[c] = q_nx[c][CH_W-1:0];
			end
		end
	end

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (rdy1) valid_s1 <= in_valid;
			if (rdy2) valid_s2 <= valid_s1;
			if (rdy3) valid_s3 <= valid_s2;
			if (rdy4) valid_s4 <= valid_s3;
		end
	end

	// Advance payload; hold each stage while it is blocked
	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			x_s1    <= x_nx;
			y_s1    <= y_nx;
			dbl_s1  <= dbl_nx;
			ctrl_s1 <= ctrl_nx;
		end
		if (rdy2 && valid_s1) begin
			for (int c = 0; c < CH_COUNT; c++) begin
				p_s2[c] <= dbl_s1[c] ? {prod_nx[c], 1'b0} : {1'b0, prod_nx[c]};
			end
			ctrl_s2 <= ctrl_s1;
		end
		if (rdy3 && valid_s2) begin
			for (int c = 0; c < CH_COUNT; c++) begin
				qe_s3[c] <= qe_sum[c][REM_W-1:CH_W];
			end
			p_s3    <= p_s2;
			ctrl_s3 <= ctrl_s2;
		end
		if (rdy4 && valid_s3) begin
			res_s4 <= res_nx;
		end
	end

	assign out_valid = valid_s4;
	assign out_red   = res_s4[0];
	assign out_green = res_s4[1];
	assign out_blue  = res_s4[2];

	// The input is only stalled while the first stage holds a word
	a_stall_needs_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input stalled with empty first stage");

	// An accepted word lands in the first stage
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> valid_s1)
		else $error("accepted word lost at first stage");

	// A blocked third stage keeps its estimate
	a_s3_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && !rdy3 |=> valid_s3 && $stable(qe_s3) && $stable(p_s3))
		else $error("blocked third stage changed");

	// The correction step never pushes a non-subtract quotient past full scale
	a_q_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && !ctrl_s3[0].sub |-> q_nx[0] <= {{(QE_W-CH_W){1'b0}}, MAXV})
		else $error("quotient out of range");

endmodule
